FILE: rtl/core/wuf_pkg.sv
// shared constants for the weighted union-find core
// no dependencies; imported by wuf_tables and weighted_union_find_core
package wuf_pkg;

    localparam int OFS_W          = 48;   // stored offset width, wraps mod 2^48
    localparam int NODE_W         = 10;   // node index field width on the stream
    localparam int DIFF_FIELD_W   = 32;   // difference field width on the stream
    localparam int NODES_DEF      = 1024;
    localparam int DIFF_WIDTH_DEF = 32;

endpackage

FILE: rtl/core/wuf_tables.sv
// parent and offset tables of the union-find forest
// one write and one registered read per cycle; depends on wuf_pkg
module wuf_tables
    import wuf_pkg::*;
#(
    parameter int NODES = NODES_DEF,
    localparam int AW   = $clog2(NODES)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [AW-1:0]    wr_parent,
    input  logic [OFS_W-1:0] wr_ofs,
    input  logic [AW-1:0]    rd_addr,
    output logic [AW-1:0]    rd_parent,
    output logic [OFS_W-1:0] rd_ofs
);

    logic [AW-1:0]    parent_mem [NODES];
    logic [OFS_W-1:0] ofs_mem    [NODES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            parent_mem[wr_addr] <= wr_parent;
            ofs_mem[wr_addr]    <= wr_ofs;
        end
    end

    always_ff @(posedge aclk) begin
        rd_parent <= parent_mem[rd_addr];
        rd_ofs    <= ofs_mem[rd_addr];
    end

endmodule

FILE: rtl/core/weighted_union_find_core.sv
// Weighted union-find core: each request asserts value(node_a) - value(node_b) = difference.
// After reset the core clears every table entry (s_tready low), then takes
// one request at a time. The work of a request grows with La + Lb, where La and Lb
// are the parent-chain lengths from node_a and node_b to their roots: every chain step
// is one read of the table memory, walked once to find the root and once more to
// compress the path. Path compression keeps chains short. A request naming a
// node >= NODES returns accepted=0, merged=0 without a table walk. The result
// waits in an output register while the next request runs.
// Depends on wuf_pkg and wuf_tables.
module weighted_union_find_core
    import wuf_pkg::*;
#(
    parameter int NODES      = NODES_DEF,
    parameter int DIFF_WIDTH = DIFF_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // node_a[9:0], node_b[19:10], difference[51:20], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // accepted[0], merged[1], zero pad
);

    localparam int AW = $clog2(NODES);
    localparam logic [31:0] NODES_U = 32'(NODES);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_START   = 3'd2;
    localparam logic [2:0] ST_WALK    = 3'd3;
    localparam logic [2:0] ST_COMP    = 3'd4;
    localparam logic [2:0] ST_RESOLVE = 3'd5;
    localparam logic [2:0] ST_HOLD    = 3'd6;

    // request fields
    logic [NODE_W-1:0]       s_node_a;
    logic [NODE_W-1:0]       s_node_b;
    logic [DIFF_FIELD_W-1:0] s_difference;
    logic [OFS_W-1:0]        diff_wide;
    logic [DIFF_WIDTH-1:0]   diff_low;
    logic [OFS_W-1:0]        diff_ofs;
    logic                    out_of_range;

    assign s_node_a     = s_tdata[9:0];
    assign s_node_b     = s_tdata[19:10];
    assign s_difference = s_tdata[51:20];
    assign diff_wide    = OFS_W'(s_difference);
    assign diff_low     = diff_wide[DIFF_WIDTH-1:0];
    assign diff_ofs     = OFS_W'($signed(diff_low));
    assign out_of_range = (32'(s_node_a) >= NODES_U) || (32'(s_node_b) >= NODES_U);

    // control state
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          out_valid_reg, out_valid_next;

    // payload state
    logic [AW-1:0]    node_a_reg, node_a_next;
    logic [AW-1:0]    node_b_reg, node_b_next;
    logic [OFS_W-1:0] diff_reg, diff_next;
    logic             side_reg, side_next;      // 0 while resolving node_a, 1 for node_b
    logic [AW-1:0]    cur_reg, cur_next;
    logic [AW-1:0]    root_reg, root_next;
    logic [OFS_W-1:0] total_reg, total_next;
    logic [OFS_W-1:0] rem_reg, rem_next;
    logic [AW-1:0]    root_a_reg, root_a_next;
    logic [OFS_W-1:0] dsa_reg, dsa_next;        // difference minus offset of node_a
    logic             res_acc_reg, res_acc_next;
    logic             res_mrg_reg, res_mrg_next;
    logic             out_acc_reg, out_acc_next;
    logic             out_mrg_reg, out_mrg_next;

    // table ports
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    wr_parent;
    logic [OFS_W-1:0] wr_ofs;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    rd_parent;
    logic [OFS_W-1:0] rd_ofs;

    logic             phase_done;
    logic [AW-1:0]    fin_root;
    logic [AW-1:0]    start_node;
    logic [OFS_W-1:0] link_ofs;

    wuf_tables #(
        .NODES(NODES)
    ) u_tables (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_parent(wr_parent),
        .wr_ofs   (wr_ofs),
        .rd_addr  (rd_addr),
        .rd_parent(rd_parent),
        .rd_ofs   (rd_ofs)
    );

    assign start_node = side_reg ? node_b_reg : node_a_reg;
    assign link_ofs   = total_reg + dsa_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_mrg_reg, out_acc_reg};

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        node_a_next    = node_a_reg;
        node_b_next    = node_b_reg;
        diff_next      = diff_reg;
        side_next      = side_reg;
        cur_next       = cur_reg;
        root_next      = root_reg;
        total_next     = total_reg;
        rem_next       = rem_reg;
        root_a_next    = root_a_reg;
        dsa_next       = dsa_reg;
        res_acc_next   = res_acc_reg;
        res_mrg_next   = res_mrg_reg;
        out_acc_next   = out_acc_reg;
        out_mrg_next   = out_mrg_reg;

        wr_en      = 1'b0;
        wr_addr    = cur_reg;
        wr_parent  = root_reg;
        wr_ofs     = rem_reg;
        rd_addr    = rd_parent;
        phase_done = 1'b0;
        fin_root   = root_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en     = 1'b1;
                wr_addr   = clr_reg;
                wr_parent = clr_reg;
                wr_ofs    = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(NODES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    node_a_next = AW'(s_node_a);
                    node_b_next = AW'(s_node_b);
                    diff_next   = diff_ofs;
                    side_next   = 1'b0;
                    cur_next    = AW'(s_node_a);
                    if (out_of_range) begin
                        res_acc_next = 1'b0;
                        res_mrg_next = 1'b0;
                        state_next   = ST_HOLD;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                rd_addr    = cur_reg;
                total_next = '0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (rd_parent == cur_reg) begin
                    // cur is the root; walk again from the start to compress
                    root_next = cur_reg;
                    rem_next  = total_reg;
                    rd_addr   = start_node;
                    cur_next  = start_node;
                    if (start_node == cur_reg) begin
                        phase_done = 1'b1;
                        fin_root   = cur_reg;
                    end else begin
                        state_next = ST_COMP;
                    end
                end else begin
                    total_next = total_reg + rd_ofs;
                    cur_next   = rd_parent;
                end
            end
            ST_COMP: begin
                // repoint cur at the root while reading the next node up
                wr_en    = 1'b1;
                rem_next = rem_reg - rd_ofs;
                cur_next = rd_parent;
                if (rd_parent == root_reg) begin
                    phase_done = 1'b1;
                end
            end
            ST_RESOLVE: begin
                if (root_a_reg != root_reg) begin
                    wr_en        = 1'b1;
                    wr_addr      = root_a_reg;
                    wr_parent    = root_reg;
                    wr_ofs       = link_ofs;
                    res_acc_next = 1'b1;
                    res_mrg_next = 1'b1;
                end else begin
                    res_acc_next = (link_ofs == '0);
                    res_mrg_next = 1'b0;
                end
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_acc_next   = res_acc_reg;
                    out_mrg_next   = res_mrg_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (phase_done) begin
            if (!side_reg) begin
                root_a_next = fin_root;
                dsa_next    = diff_reg - total_reg;
                side_next   = 1'b1;
                cur_next    = node_b_reg;
                state_next  = ST_START;
            end else begin
                root_next  = fin_root;
                state_next = ST_RESOLVE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_a_reg  <= node_a_next;
        node_b_reg  <= node_b_next;
        diff_reg    <= diff_next;
        side_reg    <= side_next;
        cur_reg     <= cur_next;
        root_reg    <= root_next;
        total_reg   <= total_next;
        rem_reg     <= rem_next;
        root_a_reg  <= root_a_next;
        dsa_reg     <= dsa_next;
        res_acc_reg <= res_acc_next;
        res_mrg_reg <= res_mrg_next;
        out_acc_reg <= out_acc_next;
        out_mrg_reg <= out_mrg_next;
    end

endmodule

FILE: bench/weighted_union_find_core_tb.sv
// self-checking bench for weighted_union_find_core: relation requests in, verdicts out
// a scoreboard class keeps its own weighted union-find and predicts each verdict
// depends on wuf_pkg and the weighted_union_find_core rtl only
`timescale 1ns / 100ps

module weighted_union_find_core_tb;
    import wuf_pkg::*;

    typedef logic [NODE_W-1:0]       node_t;
    typedef logic [OFS_W-1:0]        ofs_t;
    typedef logic [DIFF_FIELD_W-1:0] diff_t;

    class union_find_predictor;
        typedef struct {
            node_t node_a;
            node_t node_b;
            logic  accepted;
            logic  merged;
        } verdict_t;

        node_t       parent[NODES_DEF];
        ofs_t        offset[NODES_DEF];
        verdict_t    verdicts_due[$];
        int unsigned mismatches;

        function new();
            for (int i = 0; i < NODES_DEF; i++) begin
                parent[i] = node_t'(i);
                offset[i] = '0;
            end
            mismatches = 0;
        endfunction

        function int unsigned outstanding();
            return verdicts_due.size();
        endfunction

        // walks to the root, then repoints every node on the path straight at it
        function node_t find_root(input node_t x, output ofs_t to_root);
            node_t cur, root, nxt;
            ofs_t  sum, rem, old;
            cur = x;
            sum = '0;
            while (parent[cur] != cur) begin
                sum = sum + offset[cur];
                cur = parent[cur];
            end
            root = cur;
            cur = x;
            rem = sum;
            while (cur != root) begin
                nxt = parent[cur];
                old = offset[cur];
                offset[cur] = rem;
                parent[cur] = root;
                rem = rem - old;
                cur = nxt;
            end
            to_root = sum;
            return root;
        endfunction

        function void note_request(input node_t a, input node_t b, input diff_t d);
            verdict_t v;
            node_t    ra, rb;
            ofs_t     va, vb, s;
            s = {{(OFS_W - DIFF_FIELD_W){d[DIFF_FIELD_W-1]}}, d};
            v.node_a = a;
            v.node_b = b;
            v.accepted = 1'b0;
            v.merged = 1'b0;
            ra = find_root(a, va);
            rb = find_root(b, vb);
            if (ra != rb) begin
                parent[ra] = rb;
                offset[ra] = vb - va + s;
                v.accepted = 1'b1;
                v.merged = 1'b1;
            end else if (va - s == vb) begin
                v.accepted = 1'b1;
            end
            verdicts_due = {verdicts_due, v};
        endfunction

        task report_mismatch(input string msg);
            if (mismatches < 40)
                $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_verdict(input logic [7:0] word);
            verdict_t want;
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("result %02h with no request outstanding", word));
                return;
            end
            want = verdicts_due.pop_front();
            if (word[0] !== want.accepted)
                report_mismatch($sformatf("a=%0d b=%0d accepted %b, want %b",
                    want.node_a, want.node_b, word[0], want.accepted));
            if (word[1] !== want.merged)
                report_mismatch($sformatf("a=%0d b=%0d merged %b, want %b",
                    want.node_a, want.node_b, word[1], want.merged));
            if (word[7:2] !== '0)
                report_mismatch($sformatf("a=%0d b=%0d pad bits %b",
                    want.node_a, want.node_b, word[7:2]));
        endtask
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;    // node_a[9:0], node_b[19:10], difference[51:20], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // accepted[0], merged[1], zero pad

    union_find_predictor board = new();
    bit          steady = 1'b0;    // no gaps on either side while set
    int unsigned stall_left = 0;
    int          node_value[NODES_DEF];

    weighted_union_find_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("weighted_union_find_core_tb failed");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: check what was taken at this edge, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_verdict(m_tdata);
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = pick_gap();
            if (stall_left == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                stall_left--;
            end
        end
    end

    // valid stays high after acceptance; in this task only a gap lowers it
    task automatic send_relation(input node_t a, input node_t b, input diff_t d);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, d, b, a};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_request(a, b, d);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge aclk);
    endtask

    task automatic send_random_relation(input int unsigned base);
        node_t       a, b;
        diff_t       d;
        int unsigned r;
        if ($urandom_range(0, 99) < 60) begin
            // a small cluster gives many same-set checks and short merges
            a = node_t'(base + $urandom_range(0, 15));
            b = node_t'(base + $urandom_range(0, 15));
        end else begin
            a = node_t'($urandom_range(0, NODES_DEF - 1));
            b = node_t'($urandom_range(0, NODES_DEF - 1));
        end
        if ($urandom_range(0, 99) < 3)
            b = a;
        r = $urandom_range(0, 99);
        if (r < 80)
            d = diff_t'(node_value[a] - node_value[b]);
        else if (r < 92)
            d = diff_t'(node_value[a] - node_value[b] + $urandom_range(1, 4)
                        - (($urandom_range(0, 1) != 0) ? 5 : 0));
        else
            d = diff_t'($urandom());
        send_relation(a, b, d);
    endtask

    initial begin
        for (int i = 0; i < NODES_DEF; i++)
            node_value[i] = int'($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // same node, both with and without a difference
        send_relation(10'd5, 10'd5, 32'h0);
        send_relation(10'd5, 10'd5, 32'h1);
        // extreme nodes and extreme differences
        send_relation(10'd0, 10'd1023, 32'h7FFF_FFFF);
        send_relation(10'd0, 10'd1023, 32'h7FFF_FFFF);
        send_relation(10'd1023, 10'd0, 32'h8000_0001);
        send_relation(10'd0, 10'd1023, 32'h8000_0000);
        send_relation(10'd2, 10'd3, 32'h8000_0000);
        send_relation(10'd3, 10'd2, 32'h8000_0000);
        send_relation(10'd2, 10'd0, 32'hFFFF_FFFF);
        // implied offset here exceeds the 32-bit field
        send_relation(10'd3, 10'd1023, 32'hFFFF_FFFE);
        // long chain, then a walk over its full length
        for (int i = 10; i < 18; i++)
            send_relation(node_t'(i), node_t'(i + 1), 32'h1);
        send_relation(10'd10, 10'd18, 32'h8);
        send_relation(10'd10, 10'd18, 32'h7);
        send_relation(10'h2AA, 10'h155, 32'h0);
        send_relation(10'h155, 10'h2AA, 32'h0);
        send_relation(10'd1023, 10'd1023, 32'hFFFF_FFFF);
        drain_verdicts();

        for (int blk = 0; blk < 6; blk++) begin
            int unsigned base;
            base = $urandom_range(0, NODES_DEF - 16);
            steady = (blk == 2);
            for (int n = 0; n < 100; n++)
                send_random_relation(base);
            if (blk == 3)
                drain_verdicts();
        end
        steady = 1'b0;

        drain_verdicts();
        repeat (64) @(posedge aclk);
        if (board.mismatches == 0)
            $display("weighted_union_find_core_tb passed");
        else
            $display("weighted_union_find_core_tb failed");
        $finish;
    end

endmodule

FILE: weighted_union_find_core.f
rtl/core/wuf_pkg.sv
rtl/core/wuf_tables.sv
rtl/core/weighted_union_find_core.sv
bench/weighted_union_find_core_tb.sv
